FILE: rtl/dd_pkg.sv
// Shared constants, types and tables for the date difference block.
// Used by dd_serial_day and date_difference_days; no dependencies.
package dd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DIST_W   = 22;
  // Day count of one date: 365 * 16383 plus leap days and prefix stays below 2^23.
  localparam int SERIAL_W = 23;

  localparam int PRE_W    = 9;   // month prefix, up to 366
  localparam int Q100_W   = 8;   // quotient of a 12-bit value by 25
  localparam int Q400_W   = 6;   // quotient of a 10-bit value by 25

  // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for all x below 43690.
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_25 = 16'd41944;
  localparam int PROD_W      = 28;
  localparam int DIV_BASE    = 25;

  localparam int DAYS_PER_YEAR = 365;
  localparam int MONTH_FEB     = 2;
  localparam int MONTHS_YEAR   = 12;

  typedef struct packed {
    logic load_a;   // stage 1 register takes new values
    logic load_b;   // stage 2 register takes new values
  } dd_stage_en_t;

  // Days in the months that precede month m (m is 1-based, out-of-range clamped).
  function automatic logic [PRE_W-1:0] month_prefix(input logic [MONTH_W-1:0] m);
    logic [PRE_W-1:0] pre;
    begin
      case (m)
        4'd0:    pre = 9'd0;
        4'd1:    pre = 9'd0;
        4'd2:    pre = 9'd31;
        4'd3:    pre = 9'd59;
        4'd4:    pre = 9'd90;
        4'd5:    pre = 9'd120;
        4'd6:    pre = 9'd151;
        4'd7:    pre = 9'd181;
        4'd8:    pre = 9'd212;
        4'd9:    pre = 9'd243;
        4'd10:   pre = 9'd273;
        4'd11:   pre = 9'd304;
        4'd12:   pre = 9'd334;
        default: pre = 9'd365;
      endcase
      return pre;
    end
  endfunction

endpackage

FILE: rtl/dd_if.sv
// Valid/ready channel interfaces for date pairs and day distances.
// Depends on dd_pkg for field widths.
interface dd_in_if;
  logic                          valid;
  logic                          ready;
  logic [dd_pkg::DAY_W-1:0]      first_day;
  logic [dd_pkg::MONTH_W-1:0]    first_month;
  logic [dd_pkg::YEAR_W-1:0]     first_year;
  logic [dd_pkg::DAY_W-1:0]      second_day;
  logic [dd_pkg::MONTH_W-1:0]    second_month;
  logic [dd_pkg::YEAR_W-1:0]     second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

interface dd_out_if;
  logic                       valid;
  logic                       ready;
  logic [dd_pkg::DIST_W-1:0]  day_distance;

  modport source (output valid, day_distance, input ready);
  modport sink   (input valid, day_distance, output ready);
endinterface

FILE: rtl/dd_serial_day.sv
// Two pipeline stages that turn one date into a day count since year 0.
// Depends on dd_pkg; stage enables come from the top level.
module dd_serial_day (
  input  logic                            clk,
  input  dd_pkg::dd_stage_en_t            en,
  input  logic [dd_pkg::DAY_W-1:0]        day,
  input  logic [dd_pkg::MONTH_W-1:0]      month,
  input  logic [dd_pkg::YEAR_W-1:0]       year,
  output logic [dd_pkg::SERIAL_W-1:0]     serial
);

  // stage 1: reciprocal multiplies for the divisions by 100 and 400
  logic [dd_pkg::YEAR_W-1:0]   prev_year;
  logic [dd_pkg::PROD_W-1:0]   prod_p100, prod_p400, prod_y100, prod_y400;

  logic [dd_pkg::DAY_W-1:0]    s1_day;
  logic [dd_pkg::MONTH_W-1:0]  s1_month;
  logic [dd_pkg::YEAR_W-1:0]   s1_year;
  logic [dd_pkg::YEAR_W-3:0]   s1_p4;
  logic [dd_pkg::Q100_W-1:0]   s1_p100, s1_y100;
  logic [dd_pkg::Q400_W-1:0]   s1_p400, s1_y400;

  always_comb begin
    prev_year = year - dd_pkg::YEAR_W'(1);
    prod_p100 = dd_pkg::PROD_W'(prev_year[dd_pkg::YEAR_W-1:2]) *
                dd_pkg::PROD_W'(dd_pkg::RECIP_25);
    prod_p400 = dd_pkg::PROD_W'(prev_year[dd_pkg::YEAR_W-1:4]) *
                dd_pkg::PROD_W'(dd_pkg::RECIP_25);
    prod_y100 = dd_pkg::PROD_W'(year[dd_pkg::YEAR_W-1:2]) *
                dd_pkg::PROD_W'(dd_pkg::RECIP_25);
    prod_y400 = dd_pkg::PROD_W'(year[dd_pkg::YEAR_W-1:4]) *
                dd_pkg::PROD_W'(dd_pkg::RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      s1_day   <= day;
      s1_month <= month;
      s1_year  <= year;
      s1_p4    <= prev_year[dd_pkg::YEAR_W-1:2];
      s1_p100  <= prod_p100[dd_pkg::RECIP_SHIFT +: dd_pkg::Q100_W];
      s1_p400  <= prod_p400[dd_pkg::RECIP_SHIFT +: dd_pkg::Q400_W];
      s1_y100  <= prod_y100[dd_pkg::RECIP_SHIFT +: dd_pkg::Q100_W];
      s1_y400  <= prod_y400[dd_pkg::RECIP_SHIFT +: dd_pkg::Q400_W];
    end
  end

  // stage 2: leap test, year base, month prefix
  logic                        div4, div100, div400, leap;
  logic [dd_pkg::SERIAL_W-1:0] year_base, serial_next;
  logic [dd_pkg::PRE_W-1:0]    prefix;

  always_comb begin
    div4   = (s1_year[1:0] == 2'd0);
    div100 = div4 && (s1_year[dd_pkg::YEAR_W-1:2] ==
             (dd_pkg::YEAR_W-2)'(s1_y100 * (dd_pkg::YEAR_W-2)'(dd_pkg::DIV_BASE)));
    div400 = (s1_year[3:0] == 4'd0) && (s1_year[dd_pkg::YEAR_W-1:4] ==
             (dd_pkg::YEAR_W-4)'(s1_y400 * (dd_pkg::YEAR_W-4)'(dd_pkg::DIV_BASE)));
    leap   = div4 && (!div100 || div400);

    prefix = dd_pkg::month_prefix(s1_month);
    if (leap && (s1_month > dd_pkg::MONTH_W'(dd_pkg::MONTH_FEB)))
      prefix = prefix + dd_pkg::PRE_W'(1);

    // year 0 is a leap year and counted here through the +1
    if (s1_year == '0)
      year_base = '0;
    else
      year_base = dd_pkg::SERIAL_W'(s1_year) * dd_pkg::SERIAL_W'(dd_pkg::DAYS_PER_YEAR)
                + dd_pkg::SERIAL_W'(1) + dd_pkg::SERIAL_W'(s1_p4)
                - dd_pkg::SERIAL_W'(s1_p100) + dd_pkg::SERIAL_W'(s1_p400);

    serial_next = year_base + dd_pkg::SERIAL_W'(prefix) + dd_pkg::SERIAL_W'(s1_day);
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      serial <= serial_next;
    end
  end

endmodule

FILE: rtl/date_difference_days.sv
// Top level: absolute day distance between two Gregorian dates.
// Depends on dd_pkg, dd_in_if / dd_out_if and dd_serial_day.
//
// Usage:
//   dates    - sink channel; one item is a pair of dates (day, month, year).
//   distance - source channel; one item per date pair, day_distance in days.
//   An item is taken when valid and ready are high at a rising clk edge.
// Pipeline, three register stages:
//   1: year - 1 and reciprocal multiplies giving the /100 and /400 quotients
//   2: leap test, 365*y plus leap-day count, month prefix and day -> day count
//   3: difference of the two day counts, larger minus smaller, saturation
//      at 22 bits; this register drives the distance channel.
// day_distance is valid once its date pair has passed the stage 1, 2 and 3
// registers. Throughput is one item per cycle while the receiver keeps ready
// high; a stalled receiver holds the pipeline.
//
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stalled receiver holds the last stage and back-pressure
// reaches dates.ready only once all three stages are full. Nothing is dropped
// or repeated. rst (synchronous) clears the valid bits, not the data registers.
module date_difference_days (
  input  logic       clk,
  input  logic       rst,
  dd_in_if.sink      dates,
  dd_out_if.source   distance
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // ready ripples back from the output register
  always_comb begin
    rdy3 = !v3 || distance.ready;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
  end

  assign dates.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= dates.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  dd_pkg::dd_stage_en_t en;
  assign en.load_a = rdy1;
  assign en.load_b = rdy2;

  logic [dd_pkg::SERIAL_W-1:0] serial_a, serial_b;

  dd_serial_day u_first (
    .clk    (clk),
    .en     (en),
    .day    (dates.first_day),
    .month  (dates.first_month),
    .year   (dates.first_year),
    .serial (serial_a)
  );

  dd_serial_day u_second (
    .clk    (clk),
    .en     (en),
    .day    (dates.second_day),
    .month  (dates.second_month),
    .year   (dates.second_year),
    .serial (serial_b)
  );

  // stage 3: |a - b|, clipped to the output width (only years past 9999 clip)
  logic [dd_pkg::SERIAL_W-1:0] diff;
  logic [dd_pkg::DIST_W-1:0]   span_next, span;

  always_comb begin
    if (serial_a > serial_b)
      diff = serial_a - serial_b;
    else
      diff = serial_b - serial_a;

    if (diff[dd_pkg::SERIAL_W-1])
      span_next = '1;
    else
      span_next = diff[dd_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      span <= span_next;
    end
  end

  assign distance.valid        = v3;
  assign distance.day_distance = span;

endmodule

FILE: tb/dd_checker.sv
// Checker for date_difference_days: watches both channels, predicts each day distance.
// Depends on dd_pkg and on the dd_in_if / dd_out_if interfaces.
`timescale 1ns / 1ps

module dd_checker (
  input  logic clk,
  input  logic rst,
  dd_in_if     dates,
  dd_out_if    distance,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned DIST_SAT = (1 << dd_pkg::DIST_W) - 1;
  localparam int          SHOW_MAX = 10;

  logic [dd_pkg::DIST_W-1:0] distance_q[$];
  int errors = 0;

  // Day number of the date, with the first day of year zero as day 1.
  function automatic int unsigned day_number(input logic [dd_pkg::DAY_W-1:0] d,
                                             input logic [dd_pkg::MONTH_W-1:0] m,
                                             input logic [dd_pkg::YEAR_W-1:0] y);
    int unsigned cum_days[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
    int unsigned yr;
    int unsigned prev;
    int unsigned slot;
    int unsigned total;
    bit          leap;
    yr    = y;
    leap  = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    slot  = (m == 0) ? 0 : ((m > dd_pkg::MONTHS_YEAR) ? dd_pkg::MONTHS_YEAR : m - 1);
    total = cum_days[slot] + d;
    if (m > dd_pkg::MONTH_FEB && leap) total += 1;
    if (yr != 0) begin
      prev  = yr - 1;
      // year zero is a leap year too, hence the extra day
      total += dd_pkg::DAYS_PER_YEAR * yr + 1 + prev / 4 - prev / 100 + prev / 400;
    end
    return total;
  endfunction

  function automatic logic [dd_pkg::DIST_W-1:0] predict_distance(input int unsigned a,
                                                                 input int unsigned b);
    int unsigned gap;
    gap = (a > b) ? a - b : b - a;
    if (gap > DIST_SAT) gap = DIST_SAT;
    return gap[dd_pkg::DIST_W-1:0];
  endfunction

  task automatic note_failure(input string what, input logic [dd_pkg::DIST_W-1:0] want,
                              input logic [dd_pkg::DIST_W-1:0] got);
    errors++;
    if (errors <= SHOW_MAX)
      $display("%0t distance mismatch (%s): expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    logic [dd_pkg::DIST_W-1:0] want;
    if (!rst) begin
      if (distance.valid && distance.ready) begin
        if (distance_q.size() == 0) begin
          note_failure("no item outstanding", '0, distance.day_distance);
        end else begin
          want = distance_q.pop_front();
          if (distance.day_distance !== want)
            note_failure("day_distance", want, distance.day_distance);
        end
      end
      if (dates.valid && dates.ready)
        distance_q.push_back(predict_distance(
          day_number(dates.first_day, dates.first_month, dates.first_year),
          day_number(dates.second_day, dates.second_month, dates.second_year)));
    end
    fail_count <= errors;
    pending    <= distance_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the date_difference_days testbench: clock, reset, date pair stimulus, verdict.
// Depends on dd_pkg, dd_in_if / dd_out_if, the block and dd_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int PHASE_ITEMS  = 175;   // random items per idling phase
  localparam int DRAIN_CYCLES = 8;     // pipeline is 3 deep, a few extra for margin

  typedef struct packed {
    logic [dd_pkg::DAY_W-1:0]   day;
    logic [dd_pkg::MONTH_W-1:0] month;
    logic [dd_pkg::YEAR_W-1:0]  year;
  } date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int fail_count;
  int pending;
  int quiet_cycles = 0;

  dd_in_if  dates ();
  dd_out_if distance ();

  date_difference_days DUT (
    .clk      (clk),
    .rst      (rst),
    .dates    (dates),
    .distance (distance)
  );

  dd_checker u_distance_check (
    .clk        (clk),
    .rst        (rst),
    .dates      (dates),
    .distance   (distance),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Receiver: ready is redrawn at every falling edge from the current stall rate.
  initial begin
    distance.ready = 1'b0;
    forever begin
      @(negedge clk);
      distance.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (dates.valid && dates.ready) || (distance.valid && distance.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("date_difference_days regression: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  // valid is only touched once per falling edge, so back-to-back items keep it high.
  task automatic send_dates(input date_t a, input date_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      dates.valid = 1'b0;
      @(negedge clk);
    end
    dates.valid        = 1'b1;
    dates.first_day    = a.day;
    dates.first_month  = a.month;
    dates.first_year   = a.year;
    dates.second_day   = b.day;
    dates.second_month = b.month;
    dates.second_year  = b.year;
    do @(posedge clk); while (!dates.ready);
    @(negedge clk);
  endtask

  function automatic date_t mk(input int d, input int m, input int y);
    date_t t;
    t.day   = d[dd_pkg::DAY_W-1:0];
    t.month = m[dd_pkg::MONTH_W-1:0];
    t.year  = y[dd_pkg::YEAR_W-1:0];
    return t;
  endfunction

  // Mostly dates with months 1..12 and years 1..9999; the rest use the whole field range,
  // including month zero, months above twelve, day zero and years past 9999.
  task automatic send_random_pair();
    date_t a;
    date_t b;
    int    shape;
    int    y;
    int    corner_years[4] = '{0, 1, 9999, 16383};
    shape = $urandom_range(9);
    if (shape <= 5) begin
      a = mk($urandom_range(1, 28), $urandom_range(1, dd_pkg::MONTHS_YEAR),
             $urandom_range(1, 9999));
      if ($urandom_range(1)) begin
        // nearby second date: small distances and year boundaries
        y = int'(a.year) + $urandom_range(4) - 2;
        if (y < 1) y = 1;
        if (y > 9999) y = 9999;
      end else begin
        y = $urandom_range(1, 9999);
      end
      b = mk($urandom_range(1, 31), $urandom_range(1, dd_pkg::MONTHS_YEAR), y);
    end else if (shape <= 8) begin
      a = mk($urandom, $urandom, $urandom);
      b = mk($urandom, $urandom, $urandom);
    end else begin
      a = mk($urandom_range(31), $urandom_range(15), corner_years[$urandom_range(3)]);
      b = mk($urandom_range(31), $urandom_range(15), corner_years[$urandom_range(3)]);
    end
    send_dates(a, b);
  endtask

  initial begin
    dates.valid        = 1'b0;
    dates.first_day    = '0;
    dates.first_month  = '0;
    dates.first_year   = '0;
    dates.second_day   = '0;
    dates.second_month = '0;
    dates.second_year  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, no idling on either side.
    send_dates(mk(1, 1, 1),      mk(1, 1, 1));          // same date
    send_dates(mk(1, 1, 1),      mk(31, 12, 9999));     // full legal span
    send_dates(mk(31, 12, 9999), mk(1, 1, 1));          // same, first date later
    send_dates(mk(29, 2, 0),     mk(1, 3, 0));          // year zero is leap
    send_dates(mk(0, 0, 0),      mk(31, 15, 16383));    // all-zero vs all-ones, saturates
    send_dates(mk(31, 15, 16383), mk(31, 15, 16383));   // all-ones both sides
    send_dates(mk(5, 0, 2000),   mk(5, 1, 2000));       // month zero prefix
    send_dates(mk(1, 13, 2000),  mk(1, 1, 2001));       // month 13 = whole leap year
    send_dates(mk(1, 14, 1999),  mk(1, 15, 1999));      // months above twelve agree
    send_dates(mk(31, 2, 2023),  mk(0, 3, 2023));       // day out of range for month
    send_dates(mk(28, 2, 1900),  mk(1, 3, 1900));       // century, not leap
    send_dates(mk(28, 2, 2000),  mk(1, 3, 2000));       // 400 rule, leap
    send_dates(mk(28, 2, 2100),  mk(1, 3, 2100));
    send_dates(mk(28, 2, 1600),  mk(1, 3, 1600));
    send_dates(mk(31, 12, 2023), mk(1, 1, 2024));       // year boundary
    send_dates(mk(1, 1, 10000),  mk(1, 1, 1));          // beyond 9999, below saturation
    send_dates(mk(1, 1, 0),      mk(1, 1, 11492));      // just above the 22-bit limit
    send_dates(mk(0, 1, 1),      mk(31, 12, 16383));

    // Random part: no idling, sender idle, receiver stalling, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      repeat (PHASE_ITEMS) send_random_pair();
    end
    dates.valid = 1'b0;

    // Drain; the watchdog covers a pipeline that never empties.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("date_difference_days regression: pass");
    end else begin
      $display("date_difference_days regression: fail");
    end
    $finish;
  end

endmodule
